FILE: hw/rtl/hpts_pkg.sv
package hpts_pkg;

  // Pump drive codes.
  localparam logic [1:0] SPEED_OFF  = 2'd0;
  localparam logic [1:0] SPEED_LOW  = 2'd1;
  localparam logic [1:0] SPEED_HIGH = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_IDX_SETPOINT  = 3'd0;
  localparam logic [2:0] CFG_IDX_LOW_HYST  = 3'd1;
  localparam logic [2:0] CFG_IDX_HIGH_HYST = 3'd2;
  localparam logic [2:0] CFG_IDX_PRE_RUN   = 3'd3;
  localparam logic [2:0] CFG_IDX_POST_RUN  = 3'd4;
  localparam logic [2:0] CFG_IDX_SIM_MODE  = 3'd5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Register reset values and legal upper limits.
  localparam logic [9:0] SETPOINT_RST  = 10'd608;
  localparam logic [7:0] LOW_HYST_RST  = 8'd16;
  localparam logic [7:0] HIGH_HYST_RST = 8'd8;
  localparam logic [7:0] HYST_MAX      = 8'd160;
  localparam logic [9:0] PRE_RUN_RST   = 10'd30;
  localparam logic [9:0] POST_RUN_RST  = 10'd60;
  localparam logic [9:0] RUN_MAX       = 10'd600;

  // Filter gain, about 0.1 in Q16.
  localparam logic signed [13:0] FILT_GAIN = 14'sd6554;

  typedef struct packed {
    logic [9:0] setpoint_temp;
    logic [7:0] heat_margin;
    logic [7:0] stop_margin;
    logic [9:0] pre_run_seconds;
    logic [9:0] post_run_seconds;
    logic       simulation_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [11:0] temp_sample;
    logic               auto_mode;
    logic               pump_cmd_valid;
    logic [1:0]         pump_cmd_speed;
  } in_item_t;

  typedef struct packed {
    logic               heater_on;
    logic [1:0]         pump_speed;
    logic               pump_owned;
    logic [9:0]         pre_run_left;
    logic [9:0]         post_run_left;
    logic signed [11:0] filtered_temp;
    logic               interlock_tripped;
  } out_item_t;

endpackage

FILE: hw/rtl/hpts_cfg.sv
module hpts_cfg import hpts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_SETPOINT: cfg_d.setpoint_temp = cfg_wdata_i;
        CFG_IDX_LOW_HYST: begin
          cfg_d.heat_margin = (cfg_wdata_i[7:0] > HYST_MAX) ? LOW_HYST_RST
                                                             : cfg_wdata_i[7:0];
        end
        CFG_IDX_HIGH_HYST: begin
          cfg_d.stop_margin = (cfg_wdata_i[7:0] > HYST_MAX) ? HIGH_HYST_RST
                                                             : cfg_wdata_i[7:0];
        end
        CFG_IDX_PRE_RUN: begin
          cfg_d.pre_run_seconds = (cfg_wdata_i > RUN_MAX) ? PRE_RUN_RST : cfg_wdata_i;
        end
        CFG_IDX_POST_RUN: begin
          cfg_d.post_run_seconds = (cfg_wdata_i > RUN_MAX) ? POST_RUN_RST : cfg_wdata_i;
        end
        CFG_IDX_SIM_MODE: cfg_d.simulation_mode = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint_temp    <= SETPOINT_RST;
      cfg_q.heat_margin      <= LOW_HYST_RST;
      cfg_q.stop_margin      <= HIGH_HYST_RST;
      cfg_q.pre_run_seconds  <= PRE_RUN_RST;
      cfg_q.post_run_seconds <= POST_RUN_RST;
      cfg_q.simulation_mode  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/hpts_core.sv
module hpts_core import hpts_pkg::*; #(
  parameter int unsigned TIMER_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  localparam logic [16:0] TMAX = 17'((1 << TIMER_BITS) - 1);

  logic signed [11:0]    filt_q, filt_d;
  logic                  heater_q, heater_d;
  logic [1:0]            pump_q, pump_d;
  logic                  owns_q, owns_d;
  logic [TIMER_BITS-1:0] pre_q, pre_d;
  logic [TIMER_BITS-1:0] post_q, post_d;
  logic                  trip;

  logic signed [12:0]    diff;
  logic signed [26:0]    prod;
  logic signed [10:0]    filt_step;
  logic signed [12:0]    temp_ext;
  logic signed [12:0]    heat_below;
  logic signed [12:0]    stop_above;
  logic                  heat_req;
  logic                  satisfied;
  logic [16:0]           pre_cfg_ext, post_cfg_ext;
  logic [TIMER_BITS-1:0] pre_load, post_load;
  logic [16:0]           pre_out_ext, post_out_ext;

  // Filter step: the arithmetic shift gives the floor of the Q16 product.
  assign diff      = {item_i.temp_sample[11], item_i.temp_sample} - {filt_q[11], filt_q};
  assign prod      = diff * FILT_GAIN;
  assign filt_step = prod[26:16];

  assign temp_ext   = {item_i.temp_sample[11], item_i.temp_sample};
  assign heat_below = $signed({3'b000, cfg_i.setpoint_temp})
                    - $signed({5'b00000, cfg_i.heat_margin});
  assign stop_above = $signed({3'b000, cfg_i.setpoint_temp})
                    + $signed({5'b00000, cfg_i.stop_margin});
  assign heat_req   = temp_ext < heat_below;
  assign satisfied  = temp_ext > stop_above;

  // Run times saturate to what the timers can hold.
  assign pre_cfg_ext  = 17'(cfg_i.pre_run_seconds);
  assign post_cfg_ext = 17'(cfg_i.post_run_seconds);
  assign pre_load     = (pre_cfg_ext > TMAX) ? TMAX[TIMER_BITS-1:0]
                                             : pre_cfg_ext[TIMER_BITS-1:0];
  assign post_load    = (post_cfg_ext > TMAX) ? TMAX[TIMER_BITS-1:0]
                                              : post_cfg_ext[TIMER_BITS-1:0];

  always_comb begin
    heater_d = heater_q;
    pump_d   = pump_q;
    owns_d   = owns_q;
    pre_d    = pre_q;
    post_d   = post_q;
    trip     = 1'b0;

    // A manual speed code above high is ignored.
    if (item_i.pump_cmd_valid && (item_i.pump_cmd_speed <= SPEED_HIGH)) begin
      pump_d = item_i.pump_cmd_speed;
    end

    filt_d = cfg_i.simulation_mode ? filt_q : filt_q + {filt_step[10], filt_step};

    if (item_i.auto_mode) begin
      if (heat_req) begin
        if (!heater_d) begin
          if (pump_d != SPEED_OFF) begin
            if (!(owns_d && (pre_d != '0))) begin
              heater_d = 1'b1;
            end
          end else begin
            pump_d = SPEED_LOW;
            owns_d = 1'b1;
            pre_d  = pre_load;
          end
        end
      end else if (satisfied) begin
        if (heater_d) begin
          heater_d = 1'b0;
          if (owns_d) begin
            post_d = post_load;
          end
        end
      end

      if (!heater_d && owns_d && (post_d == '0) && !heat_req && (pre_d == '0)) begin
        pump_d = SPEED_OFF;
        owns_d = 1'b0;
      end

      // Interlock: never heat with the pump stopped.
      if (heater_d && (pump_d == SPEED_OFF)) begin
        pump_d = SPEED_LOW;
        owns_d = 1'b1;
        trip   = 1'b1;
      end
    end else if (owns_d) begin
      heater_d = 1'b0;
      pump_d   = SPEED_OFF;
      owns_d   = 1'b0;
      pre_d    = '0;
      post_d   = '0;
    end

    if (pre_d != '0) begin
      pre_d = pre_d - 1'b1;
    end
    if (post_d != '0) begin
      post_d = post_d - 1'b1;
    end
  end

  assign pre_out_ext  = 17'(pre_d);
  assign post_out_ext = 17'(post_d);

  always_comb begin
    res_o.heater_on         = heater_d;
    res_o.pump_speed        = pump_d;
    res_o.pump_owned        = owns_d;
    res_o.pre_run_left      = pre_out_ext[9:0];
    res_o.post_run_left     = post_out_ext[9:0];
    res_o.filtered_temp     = filt_d;
    res_o.interlock_tripped = trip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q   <= '0;
      heater_q <= 1'b0;
      pump_q   <= SPEED_OFF;
      owns_q   <= 1'b0;
      pre_q    <= '0;
      post_q   <= '0;
    end else if (step_i) begin
      filt_q   <= filt_d;
      heater_q <= heater_d;
      pump_q   <= pump_d;
      owns_q   <= owns_d;
      pre_q    <= pre_d;
      post_q   <= post_d;
    end
  end

  // A pre-run countdown only runs on a pump that auto control started.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (pre_q != '0) |-> owns_q)
    else $error("pre-run count running without pump ownership");

  // In auto mode the heater never ends a step over a stopped pump.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (step_i && item_i.auto_mode && heater_d) |-> (pump_d != SPEED_OFF))
    else $error("heater on with pump off after an auto step");

  // A tripped interlock leaves the pump at low speed and owned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (step_i && trip) |=> ((pump_q == SPEED_LOW) && owns_q && heater_q))
    else $error("interlock trip did not take the pump");

endmodule

FILE: hw/rtl/heater_pump_thermostat_sequencer_top.sv
// Path: a result beat is captured in the input register, then in the result
// register, and is offered from there, held back while out_stall_i holds.
// Throughput: one beat per cycle while out_stall_i is low; the step logic
// between the two registers carries all of an item's work, so input and
// output overlap fully.
// Reset: rst_ni clears the pipeline valids, the control state and the filter,
// and loads the configuration registers with their default values.
module heater_pump_thermostat_sequencer_top import hpts_pkg::*; #(
  parameter int unsigned TIMER_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  out_item_t out_q;
  logic      out_vld_q, out_vld_d;
  out_item_t step_res;
  logic      in_take;
  logic      advance;

  hpts_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  hpts_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(in_q),
    .cfg_i (cfg),
    .res_o (step_res)
  );

  // The held beat moves on whenever the result register is free or drains.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end

    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import hpts_pkg::*;

  localparam int TIMER_BITS = 10;
  localparam int TIMER_MAX  = (1 << TIMER_BITS) - 1;
  localparam int N_PHASES   = 8;
  localparam int PHASE_TICKS = 230;

  // Speed code 3 is not a legal drive; the block must ignore it.
  localparam logic [1:0] PUMP_BAD = 2'd3;
  // Register indexes past the last register; writes to them are dropped.
  localparam logic [2:0] CFG_IDX_SPARE6 = 3'd6;
  localparam logic [2:0] CFG_IDX_SPARE7 = 3'd7;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  heater_pump_thermostat_sequencer_top #(
    .TIMER_BITS(TIMER_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the controller: registers and control state.
  cfg_t       cfg_q;
  int         filt_q;
  logic       heat_q;
  logic [1:0] pump_q;
  logic       own_q;
  int         pre_q;
  int         post_q;

  out_item_t  pending_readings[$];
  int         tx_pct = 0;
  int         rx_pct = 0;
  int         hold_left = 0;
  int         n_ticks = 0;
  int         n_checked = 0;
  int         n_trips = 0;
  int         n_errors = 0;

  function automatic int load_timer(logic [9:0] secs);
    return (int'(secs) > TIMER_MAX) ? TIMER_MAX : int'(secs);
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [9:0] val);
    case (idx)
      CFG_IDX_SETPOINT: begin
        cfg_q.setpoint_temp = val;
      end
      CFG_IDX_LOW_HYST: begin
        cfg_q.heat_margin = (val[7:0] > HYST_MAX) ? LOW_HYST_RST : val[7:0];
      end
      CFG_IDX_HIGH_HYST: begin
        cfg_q.stop_margin = (val[7:0] > HYST_MAX) ? HIGH_HYST_RST : val[7:0];
      end
      CFG_IDX_PRE_RUN: begin
        cfg_q.pre_run_seconds = (val > RUN_MAX) ? PRE_RUN_RST : val;
      end
      CFG_IDX_POST_RUN: begin
        cfg_q.post_run_seconds = (val > RUN_MAX) ? POST_RUN_RST : val;
      end
      CFG_IDX_SIM_MODE: begin
        cfg_q.simulation_mode = val[0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic out_item_t step_thermostat(in_item_t it);
    int        t;
    int        sp;
    logic      need;
    logic      done;
    logic      trip;
    longint    prod;
    out_item_t r;
    t = $signed(it.temp_sample);
    trip = 1'b0;
    if (it.pump_cmd_valid && it.pump_cmd_speed <= SPEED_HIGH) pump_q = it.pump_cmd_speed;
    if (!cfg_q.simulation_mode) begin
      // Arithmetic shift gives the floor for negative steps as well.
      prod = longint'(t - filt_q) * 6554;
      filt_q = filt_q + int'(prod >>> 16);
    end
    if (it.auto_mode) begin
      sp = int'(cfg_q.setpoint_temp);
      need = t < sp - int'(cfg_q.heat_margin);
      done = t > sp + int'(cfg_q.stop_margin);
      if (need) begin
        if (!heat_q) begin
          if (pump_q != SPEED_OFF) begin
            if (!(own_q && pre_q > 0)) heat_q = 1'b1;
          end else begin
            pump_q = SPEED_LOW;
            own_q = 1'b1;
            pre_q = load_timer(cfg_q.pre_run_seconds);
          end
        end
      end else if (done && heat_q) begin
        heat_q = 1'b0;
        if (own_q) post_q = load_timer(cfg_q.post_run_seconds);
      end
      if (!heat_q && own_q && post_q == 0 && !need && pre_q == 0) begin
        pump_q = SPEED_OFF;
        own_q = 1'b0;
      end
      if (heat_q && pump_q == SPEED_OFF) begin
        pump_q = SPEED_LOW;
        own_q = 1'b1;
        trip = 1'b1;
      end
    end else if (own_q) begin
      heat_q = 1'b0;
      pump_q = SPEED_OFF;
      own_q = 1'b0;
      pre_q = 0;
      post_q = 0;
    end
    if (pre_q > 0) pre_q--;
    if (post_q > 0) post_q--;
    r.heater_on = heat_q;
    r.pump_speed = pump_q;
    r.pump_owned = own_q;
    r.pre_run_left = pre_q[9:0];
    r.post_run_left = post_q[9:0];
    r.filtered_temp = filt_q[11:0];
    r.interlock_tripped = trip;
    return r;
  endfunction

  function automatic dir_row_t mk_row(int temp, logic am, logic cv, logic [1:0] spd);
    dir_row_t r;
    r = '0;
    r.stim.temp_sample = temp[11:0];
    r.stim.auto_mode = am;
    r.stim.pump_cmd_valid = cv;
    r.stim.pump_cmd_speed = spd;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  // Offers one tick beat, with random idle cycles ahead of it, and records
  // the reading it must produce once the block takes it.
  task automatic send_tick(in_item_t it, logic use_typed, out_item_t typed_want);
    out_item_t w;
    while ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    w = step_thermostat(it);
    pending_readings.push_back(use_typed ? typed_want : w);
    n_ticks++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic cmp(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Result side: check each beat taken, then pick the next stall value.
  always @(posedge clk_i) begin
    out_item_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        $error("result beat with no reading pending");
        n_errors++;
      end else begin
        w = pending_readings.pop_front();
        cmp("heater_on", w.heater_on, out_data_o.heater_on);
        cmp("pump_speed", w.pump_speed, out_data_o.pump_speed);
        cmp("pump_owned", w.pump_owned, out_data_o.pump_owned);
        cmp("pre_run_left", w.pre_run_left, out_data_o.pre_run_left);
        cmp("post_run_left", w.post_run_left, out_data_o.post_run_left);
        cmp("filtered_temp", $signed(w.filtered_temp), $signed(out_data_o.filtered_temp));
        cmp("interlock_tripped", w.interlock_tripped, out_data_o.interlock_tripped);
        n_checked++;
        if (out_data_o.interlock_tripped) n_trips++;
      end
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_pct);
    end
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    dir_row_t  dir_tab[$];
    dir_row_t  row;
    in_item_t  it;
    int        walk_t;
    int        ph;
    int        k;
    int        n;

    cfg_q = '{SETPOINT_RST, LOW_HYST_RST, HIGH_HYST_RST, PRE_RUN_RST, POST_RUN_RST, 1'b0};
    filt_q = 0;
    heat_q = 1'b0;
    pump_q = SPEED_OFF;
    own_q = 1'b0;
    pre_q = 0;
    post_q = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks with the reset configuration (heat below 592, stop above 616).
    row = mk_row(0, 1'b0, 1'b0, SPEED_OFF);
    row.typed = 1'b1;
    dir_tab.push_back(row);
    // Illegal manual speed is dropped; the filter moves a tenth of the way.
    row = mk_row(2000, 1'b0, 1'b1, PUMP_BAD);
    row.typed = 1'b1;
    row.want.filtered_temp = 12'sd200;
    dir_tab.push_back(row);
    dir_tab.push_back(mk_row(-880, 1'b0, 1'b1, SPEED_HIGH));
    dir_tab.push_back(mk_row(2000, 1'b1, 1'b0, SPEED_OFF));
    // Heating over a manual pump switches the heater on at once.
    dir_tab.push_back(mk_row(-880, 1'b1, 1'b0, SPEED_OFF));
    // Pump stopped under a running heater: the interlock takes the pump.
    dir_tab.push_back(mk_row(600, 1'b1, 1'b1, SPEED_OFF));
    dir_tab.push_back(mk_row(600, 1'b0, 1'b0, SPEED_OFF));
    dir_tab.push_back(mk_row(600, 1'b0, 1'b1, SPEED_LOW));
    dir_tab.push_back(mk_row(-880, 1'b1, 1'b0, SPEED_OFF));
    // Heater over an unowned pump survives leaving auto mode.
    dir_tab.push_back(mk_row(600, 1'b0, 1'b0, SPEED_OFF));
    dir_tab.push_back(mk_row(600, 1'b0, 1'b1, SPEED_OFF));
    dir_tab.push_back(mk_row(2000, 1'b1, 1'b0, SPEED_OFF));
    // Owned start: pump first, heater waits while the pre-run counts down.
    dir_tab.push_back(mk_row(-880, 1'b1, 1'b0, SPEED_OFF));
    dir_tab.push_back(mk_row(-880, 1'b1, 1'b0, SPEED_OFF));
    dir_tab.push_back(mk_row(-880, 1'b1, 1'b1, SPEED_HIGH));
    dir_tab.push_back(mk_row(1000, 1'b1, 1'b0, SPEED_OFF));
    dir_tab.push_back(mk_row(-880, 1'b0, 1'b0, SPEED_OFF));
    dir_tab.push_back(mk_row(0, 1'b1, 1'b1, SPEED_LOW));
    dir_tab.push_back(mk_row(1000, 1'b1, 1'b0, SPEED_OFF));
    dir_tab.push_back(mk_row(-1, 1'b0, 1'b1, SPEED_OFF));
    dir_tab.push_back(mk_row(1365, 1'b0, 1'b0, SPEED_OFF));
    foreach (dir_tab[i]) send_tick(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
    wait_drained();

    walk_t = 600;
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_IDX_SETPOINT, 10'd608);
          write_reg(CFG_IDX_PRE_RUN, 10'd3);
          write_reg(CFG_IDX_POST_RUN, 10'd4);
          write_reg(CFG_IDX_SIM_MODE, 10'd0);
        end
        1: begin
          write_reg(CFG_IDX_SETPOINT, 10'd0);
          write_reg(CFG_IDX_LOW_HYST, 10'd0);
          write_reg(CFG_IDX_HIGH_HYST, 10'd0);
          write_reg(CFG_IDX_PRE_RUN, 10'd0);
          write_reg(CFG_IDX_POST_RUN, 10'd0);
          write_reg(CFG_IDX_SIM_MODE, 10'd1);
        end
        2: begin
          write_reg(CFG_IDX_SETPOINT, 10'd1023);
          write_reg(CFG_IDX_LOW_HYST, 10'd160);
          write_reg(CFG_IDX_HIGH_HYST, 10'd160);
          write_reg(CFG_IDX_PRE_RUN, 10'd600);
          write_reg(CFG_IDX_POST_RUN, 10'd600);
          write_reg(CFG_IDX_SIM_MODE, 10'd0);
        end
        3: begin
          // Values past each legal range fall back to the defaults.
          write_reg(CFG_IDX_SETPOINT, 10'd500);
          write_reg(CFG_IDX_LOW_HYST, 10'h3FF);
          write_reg(CFG_IDX_HIGH_HYST, 10'd161);
          write_reg(CFG_IDX_PRE_RUN, 10'd601);
          write_reg(CFG_IDX_POST_RUN, 10'h3FF);
          write_reg(CFG_IDX_SIM_MODE, 10'h3FE);
          write_reg(CFG_IDX_SPARE6, 10'd5);
          write_reg(CFG_IDX_SPARE7, 10'h3FF);
        end
        default: begin
          write_reg(CFG_IDX_SETPOINT, 10'($urandom_range(400, 800)));
          // Bits above the 8-bit field must be dropped before the range test.
          write_reg(CFG_IDX_LOW_HYST, 10'($urandom_range(0, 1023)));
          write_reg(CFG_IDX_HIGH_HYST, 10'($urandom_range(0, 1023)));
          write_reg(CFG_IDX_PRE_RUN, 10'(($urandom_range(9) == 0) ?
                                         $urandom_range(0, 1023) : $urandom_range(0, 8)));
          write_reg(CFG_IDX_POST_RUN, 10'(($urandom_range(9) == 0) ?
                                          $urandom_range(0, 1023) : $urandom_range(0, 8)));
          write_reg(CFG_IDX_SIM_MODE, 10'($urandom_range(0, 1)));
        end
      endcase
      cfg_we_i <= 1'b0;

      case (ph % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 54; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 54; end
        default: begin tx_pct = 30; rx_pct = 30; end
      endcase

      for (k = 0; k < PHASE_TICKS; k++) begin
        // The water warms while the heater runs and cools otherwise, so the
        // thresholds get crossed in order; rare jumps shake it up.
        if ($urandom_range(99) < 4) walk_t = int'($urandom_range(0, 2880)) - 880;
        else if (heat_q) walk_t = walk_t + int'($urandom_range(0, 6)) - 1;
        else walk_t = walk_t - int'($urandom_range(0, 5)) + 1;
        if (walk_t < -880) walk_t = -880;
        if (walk_t > 2000) walk_t = 2000;
        it.temp_sample = walk_t[11:0];
        it.auto_mode = ($urandom_range(99) < 93);
        it.pump_cmd_valid = ($urandom_range(99) < 8);
        it.pump_cmd_speed = 2'($urandom_range(0, 3));
        if (ph == 0 && k == 60) hold_left = 40;
        if (ph == 0 && k == 150) wait_drained();
        send_tick(it, 1'b0, '0);
      end
      wait_drained();
    end

    n = 0;
    while (pending_readings.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (4) @(posedge clk_i);
    $display("Run covered %0d ticks across %0d register settings, %0d readings checked,",
             n_ticks, N_PHASES + 1, n_checked);
    $display("with %0d interlock trips and all four sender/receiver idling mixes.", n_trips);
    if (n_errors == 0 && pending_readings.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (pending_readings.size() != 0)
        $error("%0d readings never arrived", pending_readings.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
